[src/pcf_pkg.sv]
package pcf_pkg;

    localparam int unsigned PALETTE_ENTRIES = 512;

    localparam logic [8:0] FULL_WEIGHT = 9'h100;

    localparam logic [14:0] RED_BITS   = 15'h001F;
    localparam logic [14:0] GREEN_BITS = 15'h03E0;
    localparam logic [14:0] BLUE_BITS  = 15'h7C00;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 15;

    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_COLOR = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FADE_SPEED   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FADE_IN      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_INDEX  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_COUNT  = 3'd4;

    localparam logic [14:0] TARGET_COLOR_RESET = 15'd0;
    localparam logic [8:0]  FADE_SPEED_RESET   = 9'd16;
    localparam logic        FADE_IN_RESET      = 1'b0;
    localparam logic [8:0]  FIRST_INDEX_RESET  = 9'd0;
    localparam logic [9:0]  ENTRY_COUNT_RESET  = 10'd512;

    localparam logic [1:0] CMD_BLEND   = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [8:0]  entry_index;
        logic [14:0] source_color;
    } item_t;

    typedef struct packed {
        logic [8:0]  out_index;
        logic [14:0] blended_color;
        logic        write_enable;
        logic        fade_done;
    } result_t;

    typedef struct packed {
        logic [14:0] target_color;
        logic [8:0]  fade_speed;
        logic        fade_in;
        logic [8:0]  first_index;
        logic [9:0]  entry_count;
    } cfg_t;

    typedef struct packed {
        logic tick;
        logic restart;
    } level_cmd_t;

endpackage

[src/pcf_cfg_regs.sv]
module pcf_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [pcf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pcf_pkg::CFG_DATA_W-1:0]    cfg_data,
    output pcf_pkg::cfg_t                     cfg
);

    pcf_pkg::cfg_t cfg_reg;
    pcf_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                pcf_pkg::REG_TARGET_COLOR: cfg_next.target_color = cfg_data[14:0];
                pcf_pkg::REG_FADE_SPEED:   cfg_next.fade_speed   = cfg_data[8:0];
                pcf_pkg::REG_FADE_IN:      cfg_next.fade_in      = cfg_data[0];
                pcf_pkg::REG_FIRST_INDEX:  cfg_next.first_index  = cfg_data[8:0];
                pcf_pkg::REG_ENTRY_COUNT:  cfg_next.entry_count  = cfg_data[9:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_color <= pcf_pkg::TARGET_COLOR_RESET;
            cfg_reg.fade_speed   <= pcf_pkg::FADE_SPEED_RESET;
            cfg_reg.fade_in      <= pcf_pkg::FADE_IN_RESET;
            cfg_reg.first_index  <= pcf_pkg::FIRST_INDEX_RESET;
            cfg_reg.entry_count  <= pcf_pkg::ENTRY_COUNT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/pcf_level.sv]
module pcf_level (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pcf_pkg::level_cmd_t   level_cmd,
    input  logic [8:0]            fade_speed,
    output logic [8:0]            weight
);

    logic [8:0] level_reg;
    logic [8:0] level_next;
    logic [9:0] level_sum;

    assign level_sum = {1'b0, level_reg} + {1'b0, fade_speed};

    always_comb
    begin
        level_next = level_reg;
        if (level_cmd.restart)
        begin
            level_next = 9'd0;
        end
        else if (level_cmd.tick)
        begin
            if (level_sum > {1'b0, pcf_pkg::FULL_WEIGHT})
            begin
                level_next = pcf_pkg::FULL_WEIGHT;
            end
            else
            begin
                level_next = level_sum[8:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= 9'd0;
        end
        else
        begin
            level_reg <= level_next;
        end
    end

    assign weight = pcf_pkg::FULL_WEIGHT - level_reg;

`ifndef SYNTHESIS
    a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= pcf_pkg::FULL_WEIGHT)
        else $error("Fade level exceeds full weight.");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        level_cmd.restart |=> level_reg == 9'd0)
        else $error("Restart did not clear the fade level.");
`endif

endmodule

[src/pcf_blend.sv]
module pcf_blend (
    input  pcf_pkg::item_t    item,
    input  pcf_pkg::cfg_t     cfg,
    input  logic [8:0]        weight,
    output pcf_pkg::result_t  result
);

    function automatic logic [14:0] blend_chan(
        input logic [14:0] src,
        input logic [14:0] tgt,
        input logic [14:0] mask,
        input logic        fin,
        input logic [8:0]  w
    );
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] d;
        logic signed [25:0] prod;
        logic signed [25:0] adj;
        logic [14:0]        base;
        logic [14:0]        q;
        logic [14:0]        sum;
        a = signed'({1'b0, src & mask});
        b = signed'({1'b0, tgt & mask});
        d = fin ? (b - a) : (a - b);
        prod = d * signed'({1'b0, w});
        // Bias negative products so the shift truncates toward zero.
        adj = prod[25] ? (prod + 26'sd255) : prod;
        q = adj[22:8];
        base = fin ? src : tgt;
        sum = q + base;
        return sum & mask;
    endfunction

    logic        in_range;
    logic [10:0] range_end;
    logic [14:0] color;

    assign range_end = {2'b00, cfg.first_index} + {1'b0, cfg.entry_count};
    assign in_range  = (item.entry_index >= cfg.first_index)
                    && ({2'b00, item.entry_index} < range_end)
                    && ({2'b00, item.entry_index} < 11'(pcf_pkg::PALETTE_ENTRIES));

    assign color = blend_chan(item.source_color, cfg.target_color, pcf_pkg::BLUE_BITS,
                              cfg.fade_in, weight)
                 | blend_chan(item.source_color, cfg.target_color, pcf_pkg::GREEN_BITS,
                              cfg.fade_in, weight)
                 | blend_chan(item.source_color, cfg.target_color, pcf_pkg::RED_BITS,
                              cfg.fade_in, weight);

    always_comb
    begin
        result = '0;
        unique case (item.command)
            pcf_pkg::CMD_BLEND:
            begin
                result.out_index = item.entry_index;
                if (in_range)
                begin
                    result.blended_color = color;
                    result.write_enable  = 1'b1;
                end
            end
            pcf_pkg::CMD_TICK:
            begin
                result.fade_done = (weight == 9'd0);
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

endmodule

[src/palette_color_fade.sv]
// Palette color fade engine for 5-5-5 palette entries.
// The item channel (item_valid, item_ready, item) carries one command per
// transaction: a blend of one palette entry, a frame tick, or a fade restart.
// Every item produces exactly one transaction on the result channel
// (result_valid, result_ready, result), in order.
// A blend returns the entry index and, when the index is in the configured
// range, the faded color with write_enable set. A tick returns fade_done when
// the weight was zero and then adds fade_speed to the fade level, up to 256.
// The item is registered at acceptance, blended combinationally, and shown
// from the result register. Throughput is one item per cycle unless the
// receiver stalls: the input stage hands its item on whenever the result
// register is empty or being read. Configuration registers are written
// through cfg_write, cfg_index and cfg_data; the user must do so only while
// no transaction is in flight, as the block does not check for it.
// Reset clears the fade level, loads the register defaults and empties both
// pipeline stages. When the receiver stalls, the result and one pending item
// are held, and item_ready drops once both stages are full.
module palette_color_fade (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [pcf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pcf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  pcf_pkg::item_t                    item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output pcf_pkg::result_t                  result
);

    pcf_pkg::cfg_t        cfg;
    pcf_pkg::level_cmd_t  level_cmd;
    logic [8:0]           weight;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    pcf_pkg::item_t       s1_item_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    pcf_pkg::result_t     out_data_reg;
    pcf_pkg::result_t     blend_result;
    logic                 s1_advance;
    logic                 item_accept;

    pcf_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pcf_level u_level (
        .clk        (clk),
        .rst_n      (rst_n),
        .level_cmd  (level_cmd),
        .fade_speed (cfg.fade_speed),
        .weight     (weight)
    );

    pcf_blend u_blend (
        .item   (s1_item_reg),
        .cfg    (cfg),
        .weight (weight),
        .result (blend_result)
    );

    assign s1_advance  = s1_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready  = !s1_valid_reg || s1_advance;
    assign item_accept = item_valid && item_ready;

    assign level_cmd.tick    = s1_advance && (s1_item_reg.command == pcf_pkg::CMD_TICK);
    assign level_cmd.restart = s1_advance && (s1_item_reg.command == pcf_pkg::CMD_RESTART);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (item_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            s1_item_reg <= item;
        end
        if (s1_advance)
        begin
            out_data_reg <= blend_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

`ifndef SYNTHESIS
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |=> s1_valid_reg && $stable(s1_item_reg))
        else $error("Pending transaction in the input stage was lost or changed.");

    a_write_or_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.write_enable && result.fade_done))
        else $error("Result flags both a palette write and fade done.");

    a_no_write_no_color: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.write_enable |-> result.blended_color == 15'd0)
        else $error("Color present on a result that writes nothing.");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> out_valid_reg)
        else $error("Advancing transaction did not reach the result register.");
`endif

endmodule
